FILE: design/lpft_pkg.sv
// shared types, constants and color expansion for the led palette flash timer
package lpft_pkg;

    localparam int NUM_LEDS      = 8;
    localparam int LED_IDX_W     = 3;
    localparam int PALETTE_DEPTH = 8;
    localparam int PADDR_W       = 3;

    localparam logic [15:0] FLASH_MS_RESET = 16'd300;
    localparam logic [7:0]  DIM_LEVEL      = 8'd30;

    // rgb565 palette
    localparam logic [15:0] PALETTE_ROM [PALETTE_DEPTH] = '{
        16'hF800, 16'h07E0, 16'h001F, 16'hFFE0,
        16'h07FF, 16'hF81F, 16'hFD20, 16'hFFFF
    };

    // register index of flash_ms on the apb port
    localparam logic REG_FLASH_MS = 1'b0;

    typedef enum logic [2:0] {
        OP_SET_COLOR = 3'd0,
        OP_TRIGGER   = 3'd1,
        OP_TICK      = 3'd2,
        OP_CLEAR     = 3'd3,
        OP_DIM       = 3'd4
    } t_op;

    typedef struct packed {
        logic [2:0]  op;
        logic [7:0]  led_index;
        logic [7:0]  color_index;
        logic [31:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic [2:0] pixel_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic                 load_color;
        logic                 arm;
        logic                 tick;
        logic                 adv;
        logic [LED_IDX_W-1:0] led;
        logic [7:0]           color;
        logic [31:0]          deadline;
        logic [31:0]          now;
    } t_cell_cmd;

    // per-cell status back to the controller
    typedef struct packed {
        logic emit;
        logic last;
    } t_cell_stat;

    // rgb565 entry expanded to 8 bits per channel, black for indexes off the rom
    function automatic t_rgb expand_color(input logic [7:0] idx);
        logic [15:0] c;
        logic [15:0] r_w;
        logic [15:0] g_w;
        logic [15:0] b_w;
        t_rgb        rgb;
        c   = PALETTE_ROM[idx[2:0]];
        r_w = 16'(c[15:11]) * 16'd527 + 16'd23;
        g_w = 16'(c[10:5]) * 16'd259 + 16'd33;
        b_w = 16'(c[4:0]) * 16'd527 + 16'd23;
        rgb = '0;
        if (idx < 8'(PALETTE_DEPTH)) begin
            rgb.red   = r_w[13:6];
            rgb.green = g_w[13:6];
            rgb.blue  = b_w[13:6];
        end
        return rgb;
    endfunction

endpackage

FILE: design/lpft_cell.sv
// one led cell: palette choice, deadline, armed and due flags, scan token
module lpft_cell
    import lpft_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [LED_IDX_W-1:0] i_cell_id,
    input  t_cell_cmd            i_cmd,
    input  logic                 i_token,
    output logic                 o_token,
    input  logic                 i_due_later,
    output logic                 o_due_chain,
    output logic [7:0]           o_color,
    output t_cell_stat           o_stat
);

    logic        r_token;
    logic        r_armed;
    logic        r_due;
    logic [7:0]  r_color;
    logic [31:0] r_deadline;
    logic        w_sel;
    logic        w_emit;

    assign w_sel  = (i_cmd.led == i_cell_id);
    assign w_emit = r_token && r_due;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_token <= 1'b0;
            r_armed <= 1'b0;
            r_due   <= 1'b0;
            r_color <= 8'(i_cell_id);
        end else begin
            if (i_cmd.adv) begin
                r_token <= i_token;
            end
            if (i_cmd.load_color && w_sel) begin
                r_color <= i_cmd.color;
            end
            if (i_cmd.arm && w_sel) begin
                r_armed <= 1'b1;
            end else if (w_emit && i_cmd.adv) begin
                r_armed <= 1'b0;
            end
            // due flags are snapshot when the tick is taken
            if (i_cmd.tick) begin
                r_due <= r_armed && (i_cmd.now >= r_deadline);
            end else if (w_emit && i_cmd.adv) begin
                r_due <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.arm && w_sel) begin
            r_deadline <= i_cmd.deadline;
        end
    end

    assign o_token     = r_token;
    assign o_due_chain = r_due || i_due_later;
    assign o_color     = r_color;
    assign o_stat.emit = w_emit;
    assign o_stat.last = !i_due_later;

endmodule

FILE: design/led_palette_flash_timer_unit.sv
// top level of the led palette flash timer: decode, cell chain, output register, apb
// writes: set color gives no output; trigger, clear and dim show their pixel write
//   on o_valid in the cycle after the input transaction
// tick: a scan token walks the cell chain one led per cycle, holding on a due led while
//   the output side stalls; no transaction is taken until the scan is done
// throughput: one transaction per cycle while no scan runs and the output side keeps up
// reset (synchronous, active low): flash_ms = 300, palette choice of led i = i, all disarmed
module led_palette_flash_timer_unit
    import lpft_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input transactions
    input  logic               i_valid,
    output logic               o_ready,
    input  t_in_item           i_data,
    // pixel write transactions
    output logic               o_valid,
    input  logic               i_ready,
    output t_out_item          o_data,
    // apb configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [15:0] r_flash_ms;
    logic        r_out_valid;
    t_out_item   r_out;

    logic        w_accept;
    logic        w_busy;
    logic        w_out_free;
    logic        w_led_ok;
    logic        w_single;
    t_out_item   w_single_item;
    t_rgb        w_rgb;
    t_cell_cmd   w_cmd;

    logic                 w_token     [NUM_LEDS+1];
    logic                 w_due_chain [NUM_LEDS+1];
    logic [7:0]           w_color     [NUM_LEDS];
    t_cell_stat           w_stat      [NUM_LEDS];
    logic [NUM_LEDS-1:0]  w_token_vec;

    logic                 w_any_emit;
    logic                 w_emit_last;
    logic [LED_IDX_W-1:0] w_emit_idx;

    // ---------------------------------------------------------------
    // apb register: flash_ms only
    // ---------------------------------------------------------------
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flash_ms <= FLASH_MS_RESET;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_FLASH_MS)) begin
            r_flash_ms <= pwdata[15:0];
        end
    end

    assign prdata = (paddr[2] == REG_FLASH_MS) ? {16'b0, r_flash_ms} : 32'b0;

    // ---------------------------------------------------------------
    // handshake: no transaction is taken while a tick scan runs;
    // the output register frees up in the same cycle it is drained
    // ---------------------------------------------------------------
    assign w_out_free = !r_out_valid || i_ready;
    assign o_ready    = !w_busy && w_out_free;
    assign w_accept   = i_valid && o_ready;

    assign w_led_ok = (i_data.led_index < 8'(NUM_LEDS));

    // palette choice of the addressed led, then rom lookup and expansion
    assign w_rgb = expand_color(w_color[i_data.led_index[LED_IDX_W-1:0]]);

    always_comb begin
        w_single      = 1'b0;
        w_single_item = '0;
        w_single_item.pixel_index = i_data.led_index[LED_IDX_W-1:0];
        w_single_item.last        = 1'b1;
        case (i_data.op)
            OP_TRIGGER: begin
                w_single = w_led_ok;
                w_single_item.red   = w_rgb.red;
                w_single_item.green = w_rgb.green;
                w_single_item.blue  = w_rgb.blue;
            end
            OP_CLEAR: begin
                w_single = w_led_ok;
            end
            OP_DIM: begin
                w_single = w_led_ok;
                w_single_item.red   = DIM_LEVEL;
                w_single_item.green = DIM_LEVEL;
                w_single_item.blue  = DIM_LEVEL;
            end
            default: begin
                w_single = 1'b0;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // command broadcast to the cells
    // ---------------------------------------------------------------
    always_comb begin
        w_cmd            = '0;
        w_cmd.load_color = w_accept && (i_data.op == OP_SET_COLOR) && w_led_ok;
        w_cmd.arm        = w_accept && (i_data.op == OP_TRIGGER) && w_led_ok;
        w_cmd.tick       = w_accept && (i_data.op == OP_TICK);
        // the scan token holds on a due led until the output register can take it
        w_cmd.adv        = !w_any_emit || w_out_free;
        w_cmd.led        = i_data.led_index[LED_IDX_W-1:0];
        w_cmd.color      = i_data.color_index;
        w_cmd.deadline   = i_data.now_ms + {16'b0, r_flash_ms};
        w_cmd.now        = i_data.now_ms;
    end

    // a tick drops the token into the first cell
    assign w_token[0]               = w_cmd.tick;
    assign w_due_chain[NUM_LEDS]    = 1'b0;

    // ---------------------------------------------------------------
    // cell chain: token runs toward higher indexes, due flags of later
    // cells run back so each cell knows whether it writes last
    // ---------------------------------------------------------------
    for (genvar k = 0; k < NUM_LEDS; k++) begin : g_cell
        lpft_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cell_id   (LED_IDX_W'(k)),
            .i_cmd       (w_cmd),
            .i_token     (w_token[k]),
            .o_token     (w_token[k+1]),
            .i_due_later (w_due_chain[k+1]),
            .o_due_chain (w_due_chain[k]),
            .o_color     (w_color[k]),
            .o_stat      (w_stat[k])
        );
        assign w_token_vec[k] = w_token[k+1];
    end

    assign w_busy = |w_token_vec;

    // at most one cell holds the token, so or-ing the requests is a mux
    always_comb begin
        w_any_emit  = 1'b0;
        w_emit_last = 1'b0;
        w_emit_idx  = '0;
        for (int k = 0; k < NUM_LEDS; k++) begin
            w_any_emit  = w_any_emit | w_stat[k].emit;
            w_emit_last = w_emit_last | (w_stat[k].emit & w_stat[k].last);
            w_emit_idx  = w_emit_idx | (w_stat[k].emit ? LED_IDX_W'(k) : '0);
        end
    end

    // ---------------------------------------------------------------
    // output register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((w_accept && w_single) || (w_any_emit && w_out_free)) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_single) begin
            r_out <= w_single_item;
        end else if (w_any_emit && w_out_free) begin
            // scan writes are always black
            r_out <= {w_emit_idx, 24'd0, w_emit_last};
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    a_token_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_token_vec))
        else $error("more than one scan token in the cell chain");

    a_tick_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.tick |=> w_token_vec[0])
        else $error("tick did not start a scan at the first cell");

    a_emit_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_any_emit |-> w_busy)
        else $error("pixel write requested outside a scan");

    a_emit_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_any_emit && w_out_free) |=>
            (r_out_valid && (r_out.last == $past(w_emit_last))
             && (r_out.pixel_index == $past(w_emit_idx))))
        else $error("scan write not captured in the output register");

endmodule

FILE: bench/lpft_pixel_checker.sv
`timescale 1ns / 1ps
// checker that predicts the pixel write transactions of the flash timer and compares them
module lpft_pixel_checker
    import lpft_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  t_in_item           i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  t_out_item          i_out_data,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic [PADDR_W-1:0] i_paddr,
    input  logic [31:0]        i_pwdata,
    input  logic               i_pready,
    output int                 o_mismatches,
    output int                 o_outstanding
);

    localparam logic [PADDR_W-1:0] FLASH_MS_ADDR = PADDR_W'(4 * int'(REG_FLASH_MS));

    logic [15:0] flash_ms_q;
    logic [7:0]  color_sel [NUM_LEDS];
    logic [31:0] off_time  [NUM_LEDS];
    logic        armed     [NUM_LEDS];
    t_out_item   pending_writes [$];
    int          mismatch_count = 0;

    // rgb565 rom entry widened to 8 bits per channel, black off the rom
    function automatic t_rgb palette_rgb(input logic [7:0] sel);
        logic [15:0] word;
        t_rgb        c;
        c = '0;
        if (int'(sel) < PALETTE_DEPTH) begin
            word    = PALETTE_ROM[sel[2:0]];
            c.red   = 8'((int'(word[15:11]) * 527 + 23) >> 6);
            c.green = 8'((int'(word[10:5]) * 259 + 33) >> 6);
            c.blue  = 8'((int'(word[4:0]) * 527 + 23) >> 6);
        end
        return c;
    endfunction

    function automatic t_out_item pixel_write(input int led, input t_rgb c, input logic is_last);
        t_out_item w;
        w.pixel_index = LED_IDX_W'(led);
        w.red         = c.red;
        w.green       = c.green;
        w.blue        = c.blue;
        w.last        = is_last;
        return w;
    endfunction

    task automatic predict_pixel_writes(input t_in_item it);
        int   led;
        int   last_due;
        int   i;
        t_rgb dim_gray;
        led      = int'(it.led_index);
        dim_gray = '{DIM_LEVEL, DIM_LEVEL, DIM_LEVEL};
        if (it.op == OP_TICK) begin
            last_due = -1;
            for (i = 0; i < NUM_LEDS; i++) begin
                if (armed[i] && it.now_ms >= off_time[i]) last_due = i;
            end
            for (i = 0; i < NUM_LEDS; i++) begin
                if (armed[i] && it.now_ms >= off_time[i]) begin
                    armed[i]    = 1'b0;
                    off_time[i] = '0;
                    pending_writes.push_back(pixel_write(i, '0, i == last_due));
                end
            end
        end else if (led < NUM_LEDS) begin
            case (it.op)
                OP_SET_COLOR: begin
                    color_sel[led] = it.color_index;
                end
                OP_TRIGGER: begin
                    pending_writes.push_back(pixel_write(led, palette_rgb(color_sel[led]), 1'b1));
                    off_time[led] = it.now_ms + 32'(flash_ms_q);
                    armed[led]    = 1'b1;
                end
                OP_CLEAR: begin
                    pending_writes.push_back(pixel_write(led, '0, 1'b1));
                end
                OP_DIM: begin
                    pending_writes.push_back(pixel_write(led, dim_gray, 1'b1));
                end
                default: ;
            endcase
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            flash_ms_q = FLASH_MS_RESET;
            for (int i = 0; i < NUM_LEDS; i++) begin
                color_sel[i] = 8'(i);
                off_time[i]  = '0;
                armed[i]     = 1'b0;
            end
            pending_writes.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (pending_writes.size() == 0) begin
                    mismatch_count++;
                    $display({"%0t unexpected pixel write: expected none, ",
                              "got led %0d rgb %h %h %h last %b"},
                             $time, i_out_data.pixel_index, i_out_data.red, i_out_data.green,
                             i_out_data.blue, i_out_data.last);
                end else begin
                    want = pending_writes.pop_front();
                    if (i_out_data !== want) begin
                        mismatch_count++;
                        $display({"%0t pixel write mismatch: ",
                                  "expected led %0d rgb %h %h %h last %b, ",
                                  "got led %0d rgb %h %h %h last %b"},
                                 $time, want.pixel_index, want.red, want.green, want.blue,
                                 want.last, i_out_data.pixel_index, i_out_data.red,
                                 i_out_data.green, i_out_data.blue, i_out_data.last);
                    end
                end
            end
            if (i_in_valid && i_in_ready) predict_pixel_writes(i_in_data);
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == FLASH_MS_ADDR) begin
                flash_ms_q = i_pwdata[15:0];
            end
        end
        o_outstanding <= pending_writes.size();
        o_mismatches  <= mismatch_count;
    end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// bench top for the led palette flash timer unit: clock, reset, stimulus and verdict
module tb;
    import lpft_pkg::*;

    // cycles with no transaction on either channel before the run is abandoned
    localparam int WATCHDOG_LIMIT  = 2000;
    // a tick scan walks every led even when it writes nothing
    localparam int DRAIN_CYCLES    = 2 * (NUM_LEDS + 1) + 4;
    localparam int ITEMS_PER_PHASE = 101;
    localparam int IDLE_PERCENT    = 28;

    localparam logic [PADDR_W-1:0] FLASH_MS_ADDR = PADDR_W'(4 * int'(REG_FLASH_MS));

    // op codes the block has no meaning for
    localparam logic [2:0] OP_UNUSED_LO = 3'd5;
    localparam logic [2:0] OP_UNUSED_HI = 3'd7;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    t_in_item           i_data  = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    t_out_item          o_data;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [31:0]        pwdata  = '0;
    logic [31:0]        prdata;
    logic               pready;

    int   mismatches;
    int   outstanding;
    int   stall_cycles = 0;
    // when set, neither side idles
    logic calm = 1'b0;

    led_palette_flash_timer_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    lpft_pixel_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_ready    (o_ready),
        .i_in_data     (i_data),
        .i_out_valid   (o_valid),
        .i_out_ready   (i_ready),
        .i_out_data    (o_data),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_pready      (pready),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // pixel side back-pressure, off during calm stretches
    always @(posedge i_clk) begin
        i_ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    // watchdog: any transaction on either channel restarts the count
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("** led_palette_flash_timer_unit: FAILED **");
                $finish;
            end
        end
    end

    function automatic t_in_item make_item(input logic [2:0] op, input logic [7:0] led,
                                           input logic [7:0] color, input logic [31:0] now);
        t_in_item it;
        it.op          = op;
        it.led_index   = led;
        it.color_index = color;
        it.now_ms      = now;
        return it;
    endfunction

    // setup cycle then access cycle; the register takes the value when pready is seen
    task automatic write_flash_ms(input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= FLASH_MS_ADDR;
        pwdata  <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // one input transaction; random idle cycles ahead of it unless calm
    task automatic send_item(input t_in_item it);
        if (!calm) begin
            while ($urandom_range(0, 99) < IDLE_PERCENT) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid <= 1'b1;
        i_data  <= it;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // wait for every predicted pixel write, then let a silent tick scan finish
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // random phase at one flash_ms setting; only items the block acts on are counted
    task automatic run_random_phase(input logic [15:0] flash, input int calm_items);
        int          counted;
        int          step_max;
        int          pick;
        logic [2:0]  op;
        logic [31:0] clock_ms;
        t_in_item    it;
        wait_drained();
        write_flash_ms(flash);
        // time steps scale with the flash length so deadlines keep getting hit
        step_max = int'(flash) / 8 + 4;
        clock_ms = $urandom;
        counted  = 0;
        while (counted < ITEMS_PER_PHASE) begin
            calm <= (counted < calm_items);
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                // noise: any op, any led, any time
                it = make_item(3'($urandom_range(0, 7)), 8'($urandom), 8'($urandom), $urandom);
            end else begin
                // occasional jump of the clock so every time bit moves
                if (pick < 12) clock_ms = $urandom;
                clock_ms = clock_ms + 32'($urandom_range(0, step_max));
                pick = $urandom_range(0, 99);
                if (pick < 15)      op = OP_SET_COLOR;
                else if (pick < 45) op = OP_TRIGGER;
                else if (pick < 72) op = OP_TICK;
                else if (pick < 86) op = OP_CLEAR;
                else                op = OP_DIM;
                it = make_item(op, 8'($urandom_range(0, NUM_LEDS - 1)),
                               ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                           : 8'($urandom_range(0, 7)),
                               clock_ms);
            end
            if (it.op <= OP_DIM && (it.op == OP_TICK || int'(it.led_index) < NUM_LEDS))
                counted++;
            send_item(it);
        end
        calm <= 1'b0;
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part at the reset flash length of 300 ms
        // every led lights in its reset palette color, white on the last one
        for (int i = 0; i < NUM_LEDS; i++) begin
            send_item(make_item(OP_TRIGGER, 8'(i), 8'd0, 32'd1000));
        end
        // one ms short of the deadline, then exactly on it: all eight go dark
        send_item(make_item(OP_TICK, 8'd0, 8'd0, 32'd1299));
        send_item(make_item(OP_TICK, 8'd0, 8'd0, 32'd1300));
        // palette indexes at the top of the rom and past it
        send_item(make_item(OP_SET_COLOR, 8'd0, 8'd7, 32'd0));
        send_item(make_item(OP_SET_COLOR, 8'd2, 8'hFF, 32'd0));
        send_item(make_item(OP_SET_COLOR, 8'd7, 8'd8, 32'd0));
        // deadline wraps past 2^32; triggers with a color off the rom still arm
        send_item(make_item(OP_TRIGGER, 8'd2, 8'd0, 32'hFFFF_FFF0));
        send_item(make_item(OP_TRIGGER, 8'd0, 8'd0, 32'd0));
        send_item(make_item(OP_TRIGGER, 8'd7, 8'd0, 32'd5000));
        // latest possible time: three due leds, last flag on led 7 only
        send_item(make_item(OP_TICK, 8'd0, 8'd0, 32'hFFFF_FFFF));
        send_item(make_item(OP_CLEAR, 8'd3, 8'd0, 32'd0));
        send_item(make_item(OP_DIM, 8'd7, 8'd0, 32'd0));
        send_item(make_item(OP_DIM, 8'd0, 8'hFF, 32'hFFFF_FFFF));
        // leds off the strip and unused op codes give nothing
        send_item(make_item(OP_TRIGGER, 8'd8, 8'd0, 32'd0));
        send_item(make_item(OP_CLEAR, 8'hFF, 8'd0, 32'd0));
        send_item(make_item(OP_UNUSED_LO, 8'd0, 8'd0, 32'd0));
        send_item(make_item(OP_UNUSED_HI, 8'd0, 8'hFF, 32'hFFFF_FFFF));
        send_item(make_item(OP_SET_COLOR, 8'hFF, 8'd0, 32'd0));

        // random phases across the flash length range, extremes included
        run_random_phase(16'd0, 0);
        run_random_phase(16'hFFFF, 0);
        run_random_phase(16'($urandom_range(1, 40)), ITEMS_PER_PHASE / 2);
        run_random_phase(FLASH_MS_RESET, 0);

        wait_drained();
        if (mismatches == 0 && outstanding == 0) begin
            $display("** led_palette_flash_timer_unit: PASSED **");
        end else begin
            $display("** led_palette_flash_timer_unit: FAILED **");
        end
        $finish;
    end

endmodule
